[design/ked_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the kirsch compass edge detector
// no dependencies

package ked_pkg;

    localparam int MAX_WIDTH_DEF = 2048;   // default line store depth
    localparam int CMP_W         = 14;     // width compares, covers line stores up to 16383
    localparam int FIFO_DEPTH    = 8;      // result queue entries
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

    // configuration register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [11:0] WIDTH_RESET  = 12'd2048;
    localparam logic [11:0] HEIGHT_RESET = 12'd4095;

    // position of the centre pixel, carried alongside the arithmetic
    typedef struct packed {
        logic        last;
        logic [11:0] row;
        logic [10:0] col;
    } tag_t;

    // one finished result, edge value in the lowest bits
    typedef struct packed {
        logic        last;
        logic [11:0] row;
        logic [10:0] col;
        logic [7:0]  edge_value;
    } result_t;

endpackage

[design/kirsch_edge_detector_unit.sv]
`timescale 1ns / 1ps
// kirsch 3x3 compass edge detector: line stores, window, compass max, result queue
// depends on ked_pkg
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata[7:0] pixel
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata edge/col/row, tlast last_of_frame
// cfg       in   cfg_valid/cfg_ready           cfg_index register, cfg_data value
//
// one pixel per clock while s_axis_tready is high; the line stores are read and written once per cycle,
// with the upper line written in the following cycle and forwarded on an address match
// a result passes stages 1 to 4 into the result queue and waits there for m_axis_tready
// reset clears counters, window, valid bits and the queue; the line stores are
// not cleared, and the upper one holds garbage until two full rows have gone through
// s_axis_tready drops only while the queue plus results in flight fill all
// FIFO_DEPTH entries; m_axis stalls never stop the pipeline itself

module kirsch_edge_detector_unit
    import ked_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] pixel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // [7:0] edge_value, [18:8] out_col, [30:19] out_row
    output logic        m_axis_tlast,    // last_of_frame
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [CMP_W-1:0] MAX_W_C = CMP_W'(MAX_WIDTH);

    // configuration registers
    logic [11:0] width_cfg_reg;
    logic [11:0] height_cfg_reg;

    // position counters
    logic [10:0] col_reg;
    logic [11:0] row_reg;
    logic [10:0] col_next;
    logic [11:0] row_next;

    // line stores
    logic [7:0] upper_mem  [0:MAX_WIDTH-1];
    logic [7:0] middle_mem [0:MAX_WIDTH-1];
    logic [7:0] up_rd_reg;
    logic [7:0] mid_rd_reg;

    // stage 1: read data arriving
    logic              s1_valid_reg;
    logic              s1_emit_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [7:0]        s1_px_reg;
    logic              s1_fwd_reg;
    logic [7:0]        s1_fwd_val_reg;
    tag_t              s1_tag_reg;

    // window and later stages
    logic [2:0][2:0][7:0] win_reg;
    logic        s2_valid_reg;
    tag_t        s2_tag_reg;
    logic        s3_valid_reg;
    tag_t        s3_tag_reg;
    logic [9:0]  s3_tri_reg [0:7];
    logic [10:0] s3_tot_reg;
    logic        s4_valid_reg;
    tag_t        s4_tag_reg;
    logic [9:0]  s4_maxs_reg;
    logic [12:0] s4_tot3_reg;

    // result queue
    result_t                 fifo_mem [0:FIFO_DEPTH-1];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   fifo_cnt_reg;
    logic [FIFO_CNT_W-1:0]   pend_reg;     // results accepted and not yet delivered

    logic              in_acc;
    logic              out_acc;
    logic              emit;
    logic              last_hit;
    logic [CMP_W-1:0]  width_eff;
    logic [CMP_W-1:0]  col_inc;
    logic [12:0]       row_inc;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        s1_up;
    logic [7:0]        ring [0:7];
    logic [9:0]        tri_sum [0:7];
    logic [10:0]       tot_sum;
    logic [9:0]        max_s;
    logic signed [13:0] resp;
    logic [7:0]        edge_val;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (pend_reg < FIFO_CNT_W'(FIFO_DEPTH));
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (fifo_cnt_reg != '0);
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = {1'b0, fifo_mem[rd_ptr_reg].row, fifo_mem[rd_ptr_reg].col,
                            fifo_mem[rd_ptr_reg].edge_value};
    assign m_axis_tlast  = fifo_mem[rd_ptr_reg].last;

    // configuration writes, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= WIDTH_RESET;
            height_cfg_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // position bookkeeping, width saturates to the line store depth
    always_comb
    begin
        width_eff = (CMP_W'(width_cfg_reg) > MAX_W_C) ? MAX_W_C : CMP_W'(width_cfg_reg);
        col_inc   = CMP_W'(col_reg) + CMP_W'(1);
        row_inc   = 13'(row_reg) + 13'd1;
        emit      = (row_reg >= 12'd2) && (col_reg >= 11'd2);
        last_hit  = (col_inc == width_eff) && (row_inc == 13'(height_cfg_reg));
        rd_addr   = ADDR_W'(col_reg);
        if (col_inc >= width_eff)
        begin
            col_next = '0;
            row_next = (row_inc >= 13'(height_cfg_reg)) ? 12'd0 : row_inc[11:0];
        end
        else
        begin
            col_next = col_inc[10:0];
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line stores: read both and write the pixel at accept, move the old
    // middle entry up in the next cycle once its read data is back
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            up_rd_reg           <= upper_mem[rd_addr];
            mid_rd_reg          <= middle_mem[rd_addr];
            middle_mem[rd_addr] <= s_axis_tdata;
        end
        if (s1_valid_reg)
            upper_mem[s1_addr_reg] <= mid_rd_reg;
    end

    // stage 1 payload, forwarding covers a back-to-back hit on the same column
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_addr_reg      <= rd_addr;
            s1_px_reg        <= s_axis_tdata;
            s1_fwd_reg       <= s1_valid_reg && (s1_addr_reg == rd_addr);
            s1_fwd_val_reg   <= mid_rd_reg;
            s1_emit_reg      <= emit;
            s1_tag_reg.last  <= last_hit;
            s1_tag_reg.row   <= row_reg - 12'd1;
            s1_tag_reg.col   <= col_reg - 11'd1;
        end
    end

    assign s1_up = s1_fwd_reg ? s1_fwd_val_reg : up_rd_reg;

    // window shifts left once per pixel, new column on the right
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (s1_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= s1_up;
            win_reg[1][2] <= mid_rd_reg;
            win_reg[2][2] <= s1_px_reg;
        end
    end

    // ring clockwise from top left; each mask weights three neighbors +5,
    // so its sum is 8*triple - 3*ring total
    always_comb
    begin
        ring[0] = win_reg[0][0];
        ring[1] = win_reg[0][1];
        ring[2] = win_reg[0][2];
        ring[3] = win_reg[1][2];
        ring[4] = win_reg[2][2];
        ring[5] = win_reg[2][1];
        ring[6] = win_reg[2][0];
        ring[7] = win_reg[1][0];
        tot_sum = '0;
        for (int k = 0; k < 8; k++)
        begin
            tri_sum[k] = 10'(ring[3'(k)]) + 10'(ring[3'(k + 1)]) + 10'(ring[3'(k + 2)]);
            tot_sum    = tot_sum + 11'(ring[k]);
        end
    end

    always_comb
    begin
        max_s = s3_tri_reg[0];
        for (int k = 1; k < 8; k++)
        begin
            if (s3_tri_reg[k] > max_s)
                max_s = s3_tri_reg[k];
        end
    end

    // best response, floor to zero, divide by eight, clamp
    always_comb
    begin
        resp = $signed({1'b0, s4_maxs_reg, 3'b000}) - $signed({1'b0, s4_tot3_reg});
        if (resp <= 14'sd0)
            edge_val = '0;
        else if (resp[12:3] > 10'd255)
            edge_val = 8'd255;
        else
            edge_val = resp[10:3];
    end

    always_ff @(posedge clk)
    begin
        s2_tag_reg  <= s1_tag_reg;
        s3_tag_reg  <= s2_tag_reg;
        s4_tag_reg  <= s3_tag_reg;
        for (int k = 0; k < 8; k++)
            s3_tri_reg[k] <= tri_sum[k];
        s3_tot_reg  <= tot_sum;
        s4_maxs_reg <= max_s;
        s4_tot3_reg <= 13'(s3_tot_reg) + {1'b0, s3_tot_reg, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_acc;
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // result queue
    always_ff @(posedge clk)
    begin
        if (s4_valid_reg)
            fifo_mem[wr_ptr_reg] <= '{last:       s4_tag_reg.last,
                                      row:        s4_tag_reg.row,
                                      col:        s4_tag_reg.col,
                                      edge_value: edge_val};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            pend_reg     <= '0;
        end
        else
        begin
            if (s4_valid_reg)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (out_acc)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            fifo_cnt_reg <= fifo_cnt_reg + FIFO_CNT_W'(s4_valid_reg) - FIFO_CNT_W'(out_acc);
            pend_reg     <= pend_reg + FIFO_CNT_W'(in_acc && emit) - FIFO_CNT_W'(out_acc);
        end
    end

    // credits never exceed the queue
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result credits exceed queue depth");

    // the queue never holds more than the credits handed out
    a_fifo_le_pend: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= pend_reg)
        else $error("queue holds more results than accepted");

    // a push never lands on a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> (fifo_cnt_reg < FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result queue overflow");

    // a repeated column on back-to-back pixels always sets the forward flag
    a_fwd_same_col: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s1_valid_reg && (s1_addr_reg == rd_addr)) |=> s1_fwd_reg)
        else $error("missed forward on repeated column");

endmodule

[tb/tb_kirsch_edge_detector_unit.sv]
`timescale 1ns / 1ps
// self-checking testbench for the kirsch compass edge detector unit
// depends on ked_pkg and kirsch_edge_detector_unit; drives pixel, result and register channels

module tb_kirsch_edge_detector_unit;
    import ked_pkg::*;

    localparam logic [1:0] REG_SPARE_2   = 2'd2;     // unmapped register slots
    localparam logic [1:0] REG_SPARE_3   = 2'd3;
    localparam int         SETTLE_CYCLES = 12;       // lets the pipeline go quiet after the results drain
    localparam int         RANDOM_PIXELS = 1750;
    localparam int         REPORT_LIMIT  = 40;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] pixel
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;     // [7:0] edge_value, [18:8] out_col, [30:19] out_row
    logic        m_axis_tlast;     // last_of_frame
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;

    // shadow of the block: line stores, 3x3 window, position counters, registers
    logic [7:0]  upper_row [MAX_WIDTH_DEF];
    logic [7:0]  middle_row [MAX_WIDTH_DEF];
    logic [7:0]  win [3][3];
    logic [10:0] col_pos;
    logic [11:0] row_pos;
    logic [11:0] width_reg;
    logic [11:0] height_reg;

    result_t     pending_edges [$];
    int          error_count;
    int          pixels_sent;
    int          gap_odds;         // 1 in n items preceded by an idle burst, 0 for none
    int          stall_odds;       // same for the result side

    kirsch_edge_detector_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result side backpressure in bursts
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_odds != 0 && $urandom_range(stall_odds - 1, 0) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(17, 1)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    function automatic void check_field(string field, int want, int got);
        if (want != got)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $error("%s mismatch: expected %0d, got %0d", field, want, got);
        end
    endfunction

    // every result transfer is matched against the oldest prediction
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_edges.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $error("unexpected result: edge_value %0d out_col %0d out_row %0d",
                           m_axis_tdata[7:0], m_axis_tdata[18:8], m_axis_tdata[30:19]);
            end
            else
            begin
                want = pending_edges.pop_front();
                check_field("edge_value", want.edge_value, m_axis_tdata[7:0]);
                check_field("out_col", want.col, m_axis_tdata[18:8]);
                check_field("out_row", want.row, m_axis_tdata[30:19]);
                check_field("last_of_frame", want.last, m_axis_tlast);
            end
        end
    end

    // one pixel transfer, then the shadow steps exactly as the block does
    task automatic send_pixel(input logic [7:0] px);
        int         ring [8];
        int         ring_sum;
        int         arc;
        int         best;
        int         eff_width;
        int         r;
        int         k;
        logic [7:0] up_px;
        logic [7:0] mid_px;
        result_t    want;
        if (gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(17, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do @(posedge clk); while (!s_axis_tready);
        pixels_sent++;

        // widths beyond the line store saturate
        eff_width = (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(width_reg);
        up_px  = upper_row[col_pos];
        mid_px = middle_row[col_pos];
        upper_row[col_pos]  = mid_px;
        middle_row[col_pos] = px;
        for (r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = up_px;
        win[1][2] = mid_px;
        win[2][2] = px;

        if (row_pos >= 2 && col_pos >= 2)
        begin
            // clockwise ring around the centre; each compass mask weights three
            // adjacent ring pixels by +5 and the other five by -3
            ring[0] = win[0][0];
            ring[1] = win[0][1];
            ring[2] = win[0][2];
            ring[3] = win[1][2];
            ring[4] = win[2][2];
            ring[5] = win[2][1];
            ring[6] = win[2][0];
            ring[7] = win[1][0];
            ring_sum = 0;
            for (k = 0; k < 8; k++)
                ring_sum += ring[k];
            best = 0;
            for (k = 0; k < 8; k++)
            begin
                arc = ring[k] + ring[(k + 1) % 8] + ring[(k + 2) % 8];
                if (8 * arc - 3 * ring_sum > best)
                    best = 8 * arc - 3 * ring_sum;
            end
            best = best / 8;
            want.edge_value = (best > 255) ? 8'd255 : best[7:0];
            want.col  = col_pos - 11'd1;
            want.row  = row_pos - 12'd1;
            want.last = (int'(col_pos) + 1 == eff_width) &&
                        (int'(row_pos) + 1 == int'(height_reg));
            pending_edges.push_back(want);
        end

        if (int'(col_pos) + 1 >= eff_width)
        begin
            col_pos = '0;
            if (int'(row_pos) + 1 >= int'(height_reg))
                row_pos = '0;
            else
                row_pos = row_pos + 12'd1;
        end
        else
        begin
            col_pos = col_pos + 11'd1;
        end
    endtask

    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(9, 0))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255, 0));
        endcase
    endfunction

    function automatic int pick_odds();
        case ($urandom_range(3, 0))
            0:       return 0;
            1:       return 3;
            2:       return 10;
            default: return 30;
        endcase
    endfunction

    task automatic send_run(input int count);
        repeat (count) send_pixel(pick_pixel());
    endtask

    // pad with pixels until the position counters are back at the frame origin
    task automatic align_frame();
        while (row_pos != 0 || col_pos != 0)
            send_pixel(pick_pixel());
    endtask

    task automatic send_frame();
        send_pixel(pick_pixel());
        align_frame();
    endtask

    // stop sending, let every result drain and the pipeline go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_edges.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] word);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_IMAGE_WIDTH)
            width_reg = word;
        else if (idx == REG_IMAGE_HEIGHT)
            height_reg = word;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [11:0] cols, input logic [11:0] rows);
        settle();
        write_reg(REG_IMAGE_WIDTH, cols);
        write_reg(REG_IMAGE_HEIGHT, rows);
    endtask

    function automatic logic [11:0] pick_width();
        if ($urandom_range(11, 0) == 0)
            return 12'($urandom_range(2, 0));
        return 12'($urandom_range(24, 3));
    endfunction

    function automatic logic [11:0] pick_height();
        if ($urandom_range(11, 0) == 0)
            return 12'($urandom_range(2, 0));
        return 12'($urandom_range(10, 3));
    endfunction

    // three full-width rows at the reset register values
    task automatic test_reset_defaults();
        gap_odds   = 30;
        stall_odds = 30;
        send_run(3 * MAX_WIDTH_DEF);
    endtask

    // width register above the line store, set while the row counter is past height
    task automatic test_wide_rows();
        configure(12'hFFF, 12'd3);
        align_frame();
        send_frame();
    endtask

    // flat bright plane, strong top edge that clamps, alternating bit pattern
    task automatic test_directed_patterns();
        logic [7:0] frames [3][9];
        int         f;
        int         k;
        frames = '{'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
                   '{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
                   '{8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55}};
        gap_odds   = 3;
        stall_odds = 3;
        configure(12'd3, 12'd3);
        for (f = 0; f < 3; f++)
            for (k = 0; k < 9; k++)
                send_pixel(frames[f][k]);
    endtask

    // narrowest legal width at the tallest height, walks the row counter to the top
    task automatic test_tall_frame();
        gap_odds   = 30;
        stall_odds = 30;
        configure(12'd3, 12'd4095);
        send_frame();
    endtask

    // widths and heights below three never produce a result
    task automatic test_degenerate_sizes();
        logic [11:0] sizes [6][2];
        int          k;
        sizes = '{'{12'd0, 12'd5}, '{12'd1, 12'd5}, '{12'd2, 12'd5},
                  '{12'd5, 12'd0}, '{12'd5, 12'd1}, '{12'd5, 12'd2}};
        gap_odds   = 10;
        stall_odds = 10;
        for (k = 0; k < 6; k++)
        begin
            configure(sizes[k][0], sizes[k][1]);
            send_run(12);
            align_frame();
        end
    endtask

    // writes to unmapped indexes must leave the geometry alone
    task automatic test_spare_indexes();
        configure(12'd4, 12'd4);
        write_reg(REG_SPARE_2, 12'd7);
        write_reg(REG_SPARE_3, 12'hFFF);
        send_frame();
        send_frame();
    endtask

    // geometry changes with the counters part way through a frame
    task automatic test_midframe_writes();
        gap_odds   = 10;
        stall_odds = 3;
        configure(12'd9, 12'd7);
        send_run(30);
        configure(12'd4, 12'd7);     // column already at the last column of the new width
        send_run(9);
        configure(12'd4, 12'd2);     // row already past the new height
        send_run(6);
        configure(12'd11, 12'd8);
        align_frame();
    endtask

    // mostly whole frames of random geometry, some broken by a mid-frame rewrite
    task automatic test_random_frames();
        int start;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_PIXELS)
        begin
            gap_odds   = pick_odds();
            stall_odds = pick_odds();
            case ($urandom_range(9, 0))
                0:
                begin
                    send_run($urandom_range(40, 1));
                    configure(pick_width(), pick_height());
                    align_frame();
                end
                1, 2:
                begin
                    configure(pick_width(), pick_height());
                    send_frame();
                end
                default:
                    send_frame();
            endcase
        end
    endtask

    // back to back transfers on both sides
    task automatic test_unthrottled_tail();
        gap_odds   = 0;
        stall_odds = 0;
        configure(12'd10, 12'd6);
        repeat (3) send_frame();
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_IMAGE_WIDTH;
        cfg_data      <= '0;
        error_count = 0;
        pixels_sent = 0;
        gap_odds    = 0;
        stall_odds  = 0;
        foreach (upper_row[i])
        begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        win        = '{default: '0};
        col_pos    = '0;
        row_pos    = '0;
        width_reg  = WIDTH_RESET;
        height_reg = HEIGHT_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_wide_rows();
        test_directed_patterns();
        test_tall_frame();
        test_degenerate_sizes();
        test_spare_indexes();
        test_midframe_writes();
        test_random_frames();
        test_unthrottled_tail();

        settle();
        if (error_count == 0)
            $display("kirsch_edge_detector_unit verification clean");
        else
            $display("kirsch_edge_detector_unit verification failed");
        $finish;
    end

    // hang guard
    initial
    begin
        #30_000_000;
        $display("kirsch_edge_detector_unit verification failed");
        $finish;
    end

endmodule
